### sv/chm_pkg.sv
// Shared types and constants of the contactor heartbeat monitor.
`default_nettype none
package chm_pkg;

  localparam int BEAT_W      = 16;
  localparam int TICK_W      = 32;
  localparam int FAIL_W      = 8;
  localparam int TRIP_W      = 4;
  localparam int BEAT_INPUTS = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [BEAT_W-1:0] BEAT_TOP = 16'hFFFF;
  localparam logic [FAIL_W-1:0] FAIL_TOP = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT   = 1'b0,
    REG_MAX_FAILS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_SCAN  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Outcome of one channel check: limit exceeded, and the channel's state if it is processed.
  typedef struct packed {
    logic              over;
    logic [BEAT_W-1:0] beat;
    logic [TICK_W-1:0] tick;
    logic [FAIL_W-1:0] fail;
  } lane_res_t;

endpackage
`default_nettype wire

### sv/contactor_heartbeat_monitor_unit.sv
// Top level of the contactor heartbeat monitor: word registers, channel lanes, state and merge.
//
// Watches the heartbeat counters of CHANNELS controllers (four beat inputs; channels past
// the fourth read a beat of zero). Each input word is either a scan (op 0) or a clear
// (op 1). A scan checks channels from 0 upward: a channel whose fail count exceeds
// max_fails sets its sticky trip bit (channels 0 to 3 only), raises dead and ends the scan,
// leaving later channels untouched. Otherwise a stored beat of 65535 wraps to 0, a beat
// that has not risen past the stored one adds a failure (saturating at 255) once the
// wrapping tick difference exceeds timeout_ticks, and a rising beat stores the beat and
// tick and clears the fail count. A clear zeroes stored beats, ticks and trips but keeps
// the fail counts, and returns dead 0 and trip_mask 0. Every input word gives exactly one
// result word. Timing: a word is captured in the input register, checked by all channel
// lanes in parallel with a priority merge while it is held there, and its result is
// held in the output register; one word is taken every cycle while the output side
// keeps up. The input register advances whenever the output register is empty or
// being drained. Configuration registers (timeout_ticks at index 0, max_fails at
// index 1) are written through cfg_we with no wait and reset to 100 and 3.
`default_nettype none
module contactor_heartbeat_monitor_unit #(
  parameter int CHANNELS = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [chm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [chm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            op,
  input  wire logic [chm_pkg::BEAT_W-1:0]      beat_lv,
  input  wire logic [chm_pkg::BEAT_W-1:0]      beat_motor,
  input  wire logic [chm_pkg::BEAT_W-1:0]      beat_array,
  input  wire logic [chm_pkg::BEAT_W-1:0]      beat_charge,
  input  wire logic [chm_pkg::TICK_W-1:0]      now_tick,
  // result words
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 dead,
  output logic [chm_pkg::TRIP_W-1:0]           trip_mask
);
  import chm_pkg::*;

  // Configuration registers
  logic [TICK_W-1:0] timeout_ticks;
  logic [FAIL_W-1:0] max_fails;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TICK_W'(100);
      max_fails     <= FAIL_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT:   timeout_ticks <= cfg_data[TICK_W-1:0];
        REG_MAX_FAILS: max_fails     <= cfg_data[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic              s1_valid;
  logic              s1_op;
  logic [BEAT_W-1:0] s1_beat [BEAT_INPUTS];
  logic [TICK_W-1:0] s1_now;
  logic              proc;

  // Process the held word when the output register can take its result.
  assign proc     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op      <= op;
      s1_beat[0] <= beat_lv;
      s1_beat[1] <= beat_motor;
      s1_beat[2] <= beat_array;
      s1_beat[3] <= beat_charge;
      s1_now     <= now_tick;
    end
  end

  // Channel state
  logic [BEAT_W-1:0] last_beat  [CHANNELS];
  logic [TICK_W-1:0] last_tick  [CHANNELS];
  logic [FAIL_W-1:0] fail_count [CHANNELS];
  logic [TRIP_W-1:0] trips;

  logic [BEAT_W-1:0] last_beat_next  [CHANNELS];
  logic [TICK_W-1:0] last_tick_next  [CHANNELS];
  logic [FAIL_W-1:0] fail_count_next [CHANNELS];
  logic [TRIP_W-1:0] trips_next;
  logic              dead_next;

  lane_res_t lane [CHANNELS];

  // One lane per channel; channels with no beat input see zero.
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    logic [BEAT_W-1:0] lane_beat;
    if (g < BEAT_INPUTS) begin : g_beat
      assign lane_beat = s1_beat[g];
    end else begin : g_zero
      assign lane_beat = '0;
    end

    chm_lane u_lane (
      .last_beat     (last_beat[g]),
      .last_tick     (last_tick[g]),
      .fail_count    (fail_count[g]),
      .beat          (lane_beat),
      .now_tick      (s1_now),
      .timeout_ticks (timeout_ticks),
      .max_fails     (max_fails),
      .res           (lane[g])
    );
  end

  // Priority merge: the first channel over its limit ends the scan.
  always_comb begin
    logic blocked;
    blocked    = 1'b0;
    dead_next  = 1'b0;
    trips_next = trips;
    for (int i = 0; i < CHANNELS; i++) begin
      last_beat_next[i]  = last_beat[i];
      last_tick_next[i]  = last_tick[i];
      fail_count_next[i] = fail_count[i];
      if (s1_op == OP_CLEAR) begin
        last_beat_next[i] = '0;
        last_tick_next[i] = '0;
      end else if (!blocked) begin
        if (lane[i].over) begin
          blocked   = 1'b1;
          dead_next = 1'b1;
          if (i < TRIP_W) begin
            trips_next[i[$clog2(TRIP_W)-1:0]] = 1'b1;
          end
        end else begin
          last_beat_next[i]  = lane[i].beat;
          last_tick_next[i]  = lane[i].tick;
          fail_count_next[i] = lane[i].fail;
        end
      end
    end
    if (s1_op == OP_CLEAR) begin
      trips_next = '0;
      dead_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_beat[i]  <= '0;
        last_tick[i]  <= '0;
        fail_count[i] <= '0;
      end
      trips <= '0;
    end else if (proc) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_beat[i]  <= last_beat_next[i];
        last_tick[i]  <= last_tick_next[i];
        fail_count[i] <= fail_count_next[i];
      end
      trips <= trips_next;
    end
  end

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      dead      <= dead_next;
      trip_mask <= trips_next;
    end
  end

  // Checks
  a_clear_zeroes_trips: assert property (@(posedge clk) disable iff (rst)
    proc && (s1_op == OP_CLEAR) |=> (trips == '0) && out_valid && !dead && (trip_mask == '0))
    else $error("clear word left trips or a dead result");

  a_trips_sticky: assert property (@(posedge clk) disable iff (rst)
    proc && (s1_op == OP_SCAN) |=> ((trips & $past(trips)) == $past(trips)))
    else $error("scan dropped a sticky trip bit");

  a_mask_matches_state: assert property (@(posedge clk) disable iff (rst)
    proc |=> out_valid && (trip_mask == trips))
    else $error("result trip mask differs from stored trips");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !proc)
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

### sv/chm_lane.sv
// One channel check: fail-limit test, stored value wrap, timeout count and update.
`default_nettype none
module chm_lane (
  input  wire logic [chm_pkg::BEAT_W-1:0] last_beat,
  input  wire logic [chm_pkg::TICK_W-1:0] last_tick,
  input  wire logic [chm_pkg::FAIL_W-1:0] fail_count,
  input  wire logic [chm_pkg::BEAT_W-1:0] beat,
  input  wire logic [chm_pkg::TICK_W-1:0] now_tick,
  input  wire logic [chm_pkg::TICK_W-1:0] timeout_ticks,
  input  wire logic [chm_pkg::FAIL_W-1:0] max_fails,
  output chm_pkg::lane_res_t              res
);
  import chm_pkg::*;

  logic [BEAT_W-1:0] base;
  logic [TICK_W-1:0] elapsed;

  // Wrap a stored value at the top back to zero.
  assign base    = (last_beat == BEAT_TOP) ? '0 : last_beat;
  assign elapsed = now_tick - last_tick;

  always_comb begin
    res.over = (fail_count > max_fails);
    res.beat = base;
    res.tick = last_tick;
    res.fail = fail_count;
    if (base >= beat) begin
      if ((elapsed > timeout_ticks) && (fail_count != FAIL_TOP)) begin
        res.fail = fail_count + FAIL_W'(1);
      end
    end else begin
      res.beat = beat;
      res.tick = now_tick;
      res.fail = '0;
    end
  end

endmodule
`default_nettype wire
